// ===== hw/rtl/lpp_pkg.sv =====
package lpp_pkg;

  // one raw byte of the pair region as it crosses the input queue
  typedef struct packed {
    logic       start_region;
    logic [7:0] data_byte;
  } item_t;

  // one parser result as it waits in the output queue
  typedef struct packed {
    logic        value_valid;
    logic [7:0]  value_byte;
    logic [31:0] pair_id;
    logic        pair_end;
    logic [31:0] pair_index;
    logic [1:0]  parse_status;
  } result_t;

  // both queues hold two beats
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ===== hw/rtl/lpp_front.sv =====
module lpp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  lpp_pkg::item_t item_in,
  output logic           deq_valid,
  input  logic           deq_ready,
  output lpp_pkg::item_t item_out
);
  import lpp_pkg::*;

  item_t      mem [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  // handshake on both sides of the queue
  assign full      = (count == 2'(QUEUE_DEPTH));
  assign deq_valid = (count != 2'd0);
  assign do_wr     = push && !full;
  assign do_rd     = deq_valid && deq_ready;
  assign item_out  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= item_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/lpp_back.sv =====
module lpp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      region_length,
  input  logic             enq_valid,
  output logic             enq_ready,
  input  lpp_pkg::item_t   item_in,
  output logic             empty,
  input  logic             pop,
  output lpp_pkg::result_t result_out
);
  import lpp_pkg::*;

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_ID   = 2'd1;
  localparam logic [1:0] PH_VAL  = 2'd2;
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;
  localparam logic [63:0] INT_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [31:0] U32_TOP = 32'hFFFF_FFFF;

  // parser state
  logic [31:0] byte_offset;
  logic [1:0]  field_phase;
  logic [63:0] length_shift;
  logic [31:0] id_shift;
  logic [31:0] value_remaining;
  logic [31:0] pairs_done;
  logic [1:0]  status_reg;
  logic [2:0]  phase_byte_count;

  logic [31:0] byte_offset_next;
  logic [1:0]  field_phase_next;
  logic [63:0] length_shift_next;
  logic [31:0] id_shift_next;
  logic [31:0] value_remaining_next;
  logic [31:0] pairs_done_next;
  logic [1:0]  status_reg_next;
  logic [2:0]  phase_byte_count_next;

  // state after an optional start-of-region clear
  logic        clr;
  logic [31:0] e_off;
  logic [1:0]  e_phase;
  logic [63:0] e_len;
  logic [31:0] e_id;
  logic [31:0] e_vrem;
  logic [31:0] e_pairs;
  logic [1:0]  e_status;
  logic [2:0]  e_cnt;

  logic [31:0] off_inc;
  logic [31:0] left_now;
  logic [31:0] left_after;
  logic [2:0]  cnt_inc;
  logic [63:0] len_new;
  logic [31:0] id_new;
  logic [7:0]  b;
  result_t     res;

  // output queue
  result_t     oq [QUEUE_DEPTH];
  logic        oq_wr_ptr;
  logic        oq_rd_ptr;
  logic [1:0]  oq_count;
  logic        step;
  logic        do_pop;

  assign enq_ready  = (oq_count != 2'(QUEUE_DEPTH));
  assign step       = enq_valid && enq_ready;
  assign empty      = (oq_count == 2'd0);
  assign do_pop     = pop && !empty;
  assign result_out = oq[oq_rd_ptr];

  assign clr      = item_in.start_region;
  assign b        = item_in.data_byte;
  assign e_off    = clr ? 32'd0   : byte_offset;
  assign e_phase  = clr ? PH_LEN  : field_phase;
  assign e_len    = clr ? 64'd0   : length_shift;
  assign e_id     = clr ? 32'd0   : id_shift;
  assign e_vrem   = clr ? 32'd0   : value_remaining;
  assign e_pairs  = clr ? 32'd0   : pairs_done;
  assign e_status = clr ? ST_BUSY : status_reg;
  assign e_cnt    = clr ? 3'd0    : phase_byte_count;

  // offset after this byte and bytes left before and after it
  assign off_inc    = (e_off == U32_TOP) ? e_off : e_off + 32'd1;
  assign left_now   = (region_length > e_off)   ? region_length - e_off   : 32'd0;
  assign left_after = (region_length > off_inc) ? region_length - off_inc : 32'd0;
  assign cnt_inc    = e_cnt + 3'd1;
  assign len_new    = {b, e_len[63:8]};
  assign id_new     = {b, e_id[31:8]};

  // one parse step per beat
  always_comb begin
    byte_offset_next      = e_off;
    field_phase_next      = e_phase;
    length_shift_next     = e_len;
    id_shift_next         = e_id;
    value_remaining_next  = e_vrem;
    pairs_done_next       = e_pairs;
    status_reg_next       = e_status;
    phase_byte_count_next = e_cnt;
    res                   = '0;
    res.pair_index        = e_pairs;

    if (e_status == ST_BUSY) begin
      case (e_phase)
        PH_ID: begin
          byte_offset_next      = off_inc;
          id_shift_next         = id_new;
          phase_byte_count_next = cnt_inc;
          if (cnt_inc[2]) begin
            res.pair_id = id_new;
            if (e_vrem == 32'd0) begin
              res.pair_end = 1'b1;
            end else begin
              field_phase_next      = PH_VAL;
              phase_byte_count_next = 3'd0;
            end
          end
        end
        PH_VAL: begin
          byte_offset_next     = off_inc;
          res.value_valid      = 1'b1;
          res.value_byte       = b;
          res.pair_id          = e_id;
          value_remaining_next = e_vrem - 32'd1;
          if (e_vrem == 32'd1) begin
            res.pair_end = 1'b1;
          end
        end
        default: begin
          if (e_cnt == 3'd0 && left_now < 32'd8) begin
            // short tail at a pair boundary
            status_reg_next = ST_DONE;
          end else begin
            byte_offset_next      = off_inc;
            length_shift_next     = len_new;
            phase_byte_count_next = cnt_inc;
            if (cnt_inc == 3'd0) begin
              if (len_new < 64'd4 || len_new > INT_MAX ||
                  len_new > {32'd0, left_after}) begin
                status_reg_next = ST_ERR;
              end else begin
                value_remaining_next  = len_new[31:0] - 32'd4;
                id_shift_next         = 32'd0;
                field_phase_next      = PH_ID;
                phase_byte_count_next = 3'd0;
              end
            end
          end
        end
      endcase

      // pair completion
      if (res.pair_end) begin
        pairs_done_next       = (e_pairs == U32_TOP) ? e_pairs : e_pairs + 32'd1;
        field_phase_next      = PH_LEN;
        phase_byte_count_next = 3'd0;
        length_shift_next     = 64'd0;
        if (left_after < 32'd8) begin
          status_reg_next = ST_DONE;
        end
      end
    end

    res.parse_status = status_reg_next;
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= 32'd0;
      field_phase      <= PH_LEN;
      length_shift     <= 64'd0;
      id_shift         <= 32'd0;
      value_remaining  <= 32'd0;
      pairs_done       <= 32'd0;
      status_reg       <= ST_BUSY;
      phase_byte_count <= 3'd0;
    end else if (step) begin
      byte_offset      <= byte_offset_next;
      field_phase      <= field_phase_next;
      length_shift     <= length_shift_next;
      id_shift         <= id_shift_next;
      value_remaining  <= value_remaining_next;
      pairs_done       <= pairs_done_next;
      status_reg       <= status_reg_next;
      phase_byte_count <= phase_byte_count_next;
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (step) begin
      oq[oq_wr_ptr] <= res;
    end
  end

  // output queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr_ptr <= 1'b0;
      oq_rd_ptr <= 1'b0;
      oq_count  <= 2'd0;
    end else begin
      if (step) begin
        oq_wr_ptr <= ~oq_wr_ptr;
      end
      if (do_pop) begin
        oq_rd_ptr <= ~oq_rd_ptr;
      end
      if (step && !do_pop) begin
        oq_count <= oq_count + 2'd1;
      end else if (do_pop && !step) begin
        oq_count <= oq_count - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/length_prefixed_id_value_parser.sv =====
// channel   | handshake                 | beat
// ----------+---------------------------+---------------------------------------------
// input     | push / full               | start_region, data_byte
// result    | empty / pop               | value_valid, value_byte, pair_id, pair_end,
//           |                           | pair_index, parse_status
// config    | cfg_we                    | cfg_wdata -> region_length
//
// One byte per cycle sustained while pop keeps up; a result is on the ports once its byte
// has passed the input queue, then the parse step into the output queue.
// The parse step is a single registered pass of counter, shift and compare updates.
// rst is synchronous; it empties both two-beat queues and clears region_length.
// A stalled pop backs up the output queue, then the input queue, then full.
module length_prefixed_id_value_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        start_region,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic        value_valid,
  output logic [7:0]  value_byte,
  output logic [31:0] pair_id,
  output logic        pair_end,
  output logic [31:0] pair_index,
  output logic [1:0]  parse_status
);
  import lpp_pkg::*;

  logic [31:0] region_length;
  item_t       in_item;
  item_t       mid_item;
  logic        mid_valid;
  logic        mid_ready;
  result_t     res;

  // region length register
  always_ff @(posedge clk) begin
    if (rst) begin
      region_length <= 32'd0;
    end else if (cfg_we) begin
      region_length <= cfg_wdata;
    end
  end

  assign in_item.start_region = start_region;
  assign in_item.data_byte    = data_byte;

  // input queue
  lpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item_in   (in_item),
    .deq_valid (mid_valid),
    .deq_ready (mid_ready),
    .item_out  (mid_item)
  );

  // parser and output queue
  lpp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .region_length (region_length),
    .enq_valid     (mid_valid),
    .enq_ready     (mid_ready),
    .item_in       (mid_item),
    .empty         (empty),
    .pop           (pop),
    .result_out    (res)
  );

  assign value_valid  = res.value_valid;
  assign value_byte   = res.value_byte;
  assign pair_id      = res.pair_id;
  assign pair_end     = res.pair_end;
  assign pair_index   = res.pair_index;
  assign parse_status = res.parse_status;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lpp_pkg::*;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;
  localparam logic [63:0] INT_MAX = 64'h7FFF_FFFF;
  localparam int RAND_ITEMS = 1100;
  localparam int CALM_ITEMS = 150;
  localparam int QUIET_LIMIT = 1000;

  typedef enum logic [1:0] {PH_LENGTH, PH_IDENT, PH_VALUE} phase_t;

  // one directed stimulus row, optional register write ahead of the beat
  typedef struct packed {
    bit          wr;
    logic [31:0] cfg;
    logic        st;
    logic [7:0]  b;
    bit          fixed;
    logic [1:0]  status;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  logic        start_region = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        value_valid;
  logic [7:0]  value_byte;
  logic [31:0] pair_id;
  logic        pair_end;
  logic [31:0] pair_index;
  logic [1:0]  parse_status;

  length_prefixed_id_value_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .start_region (start_region),
    .data_byte    (data_byte),
    .empty        (empty),
    .pop          (pop),
    .value_valid  (value_valid),
    .value_byte   (value_byte),
    .pair_id      (pair_id),
    .pair_end     (pair_end),
    .pair_index   (pair_index),
    .parse_status (parse_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // parser state mirror
  logic [31:0] rgn_len = '0;
  logic [31:0] off_cnt = '0;
  phase_t      phase = PH_LENGTH;
  logic [63:0] len_sr = '0;
  logic [31:0] id_sr = '0;
  logic [31:0] val_left = '0;
  logic [31:0] pairs_cnt = '0;
  logic [1:0]  status = ST_BUSY;
  logic [2:0]  fld_cnt = '0;

  result_t     due_results[$];
  logic [7:0]  region_q[$];
  int          len_pos[$];
  int          item_cnt = 0;
  int          region_starts = 0;
  int          pairs_closed = 0;
  int          len_errors = 0;
  int          clean_ends = 0;
  int          checked = 0;
  int          mismatches = 0;
  bit          bursts_on = 1'b1;
  int          stall_left = 0;
  int          quiet_cnt = 0;

  function automatic logic [31:0] room_left();
    return (rgn_len > off_cnt) ? rgn_len - off_cnt : 32'd0;
  endfunction

  // pair complete: back to the length field, then the short tail check
  function automatic void close_pair();
    if (pairs_cnt != '1) pairs_cnt++;
    pairs_closed++;
    phase = PH_LENGTH;
    fld_cnt = '0;
    len_sr = '0;
    if (room_left() < 32'd8) begin
      status = ST_DONE;
      clean_ends++;
    end
  endfunction

  // expected result of one byte, advances the mirrored state
  function automatic result_t parse_byte(input logic st, input logic [7:0] b);
    result_t r;
    r = '0;
    if (st) begin
      off_cnt = '0;
      phase = PH_LENGTH;
      len_sr = '0;
      id_sr = '0;
      val_left = '0;
      pairs_cnt = '0;
      status = ST_BUSY;
      fld_cnt = '0;
    end
    r.pair_index = pairs_cnt;
    if (status == ST_BUSY) begin
      case (phase)
        PH_IDENT: begin
          if (off_cnt != '1) off_cnt++;
          id_sr = {b, id_sr[31:8]};
          fld_cnt = fld_cnt + 3'd1;
          if (fld_cnt >= 3'd4) begin
            r.pair_id = id_sr;
            if (val_left == '0) begin
              r.pair_end = 1'b1;
              close_pair();
            end else begin
              phase = PH_VALUE;
              fld_cnt = '0;
            end
          end
        end
        PH_VALUE: begin
          if (off_cnt != '1) off_cnt++;
          r.value_valid = 1'b1;
          r.value_byte = b;
          r.pair_id = id_sr;
          val_left = val_left - 32'd1;
          if (val_left == '0) begin
            r.pair_end = 1'b1;
            close_pair();
          end
        end
        default: begin
          if (fld_cnt == '0 && room_left() < 32'd8) begin
            status = ST_DONE;
            clean_ends++;
          end
          if (status == ST_BUSY) begin
            if (off_cnt != '1) off_cnt++;
            len_sr = {b, len_sr[63:8]};
            fld_cnt = fld_cnt + 3'd1;
            if (fld_cnt == '0) begin
              if (len_sr < 64'd4 || len_sr > INT_MAX ||
                  len_sr > {32'd0, room_left()}) begin
                status = ST_ERROR;
                len_errors++;
              end else begin
                val_left = len_sr[31:0] - 32'd4;
                id_sr = '0;
                phase = PH_IDENT;
                fld_cnt = '0;
              end
            end
          end
        end
      endcase
    end
    r.parse_status = status;
    return r;
  endfunction

  function automatic dir_row_t dir_row(input bit wr, input logic [31:0] cfg,
                                       input logic st, input logic [7:0] b,
                                       input bit fixed, input logic [1:0] status_want);
    dir_row_t d;
    d.wr = wr;
    d.cfg = cfg;
    d.st = st;
    d.b = b;
    d.fixed = fixed;
    d.status = status_want;
    return d;
  endfunction

  // push one byte beat, predict at the accepting edge, maybe leave a gap
  task automatic send_byte(input logic st, input logic [7:0] b, input bit fixed,
                           input result_t fixed_res);
    result_t r;
    push <= 1'b1;
    start_region <= st;
    data_byte <= b;
    do @(posedge clk); while (full);
    r = parse_byte(st, b);
    if (fixed) r = fixed_res;
    due_results.insert(due_results.size(), r);
    item_cnt++;
    if (st) region_starts++;
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_region_len(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rgn_len = v;
  endtask

  // well-formed pairs with random content, a short tail, sometimes one bad length
  task automatic build_region();
    int n;
    int vlen;
    int p;
    logic [63:0] plen;
    region_q.delete();
    len_pos.delete();
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      vlen = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      plen = 64'(vlen) + 64'd4;
      len_pos.insert(len_pos.size(), region_q.size());
      for (int k = 0; k < 8; k++) region_q.insert(region_q.size(), plen[8*k +: 8]);
      for (int k = 0; k < 4 + vlen; k++) region_q.insert(region_q.size(), 8'($urandom));
    end
    repeat ($urandom_range(0, 7)) region_q.insert(region_q.size(), 8'($urandom));
    if ($urandom_range(0, 9) >= 6) begin
      p = len_pos[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 3))
        0: plen = 64'($urandom_range(0, 3));
        1: plen = $urandom_range(0, 1) ? 64'h8000_0000 : ({$urandom, $urandom} | 64'h8000_0000);
        2: plen = 64'(region_q.size() - (p + 8)) + 64'($urandom_range(1, 3));
        default: plen = INT_MAX;
      endcase
      for (int k = 0; k < 8; k++) region_q[p + k] = plen[8*k +: 8];
    end
  endtask

  task automatic run_region(input bit split);
    int sz;
    int cut;
    logic [31:0] cfg;
    result_t none;
    none = '0;
    build_region();
    sz = region_q.size();
    case ($urandom_range(0, 9))
      0: cfg = '1;
      1: cfg = 32'(sz + $urandom_range(1, 12));
      2: cfg = 32'(sz - $urandom_range(0, 6));
      default: cfg = 32'(sz);
    endcase
    wait_idle();
    write_region_len(cfg);
    cut = split ? $urandom_range(1, sz - 1) : sz;
    for (int i = 0; i < cut; i++) send_byte(i == 0, region_q[i], 1'b0, none);
    if (split) begin
      // new length mid-region, possibly below the bytes already consumed
      wait_idle();
      case ($urandom_range(0, 2))
        0: cfg = 32'($urandom_range(0, cut));
        1: cfg = cfg + 32'($urandom_range(0, 20));
        default: cfg = 32'(sz);
      endcase
      write_region_len(cfg);
      for (int i = cut; i < sz; i++) send_byte(1'b0, region_q[i], 1'b0, none);
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'($urandom), 1'b0, none);
  endtask

  task automatic run_noise();
    result_t none;
    none = '0;
    wait_idle();
    write_region_len($urandom_range(0, 1) ? 32'($urandom_range(0, 40)) : 32'($urandom));
    send_byte(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, none);
    repeat ($urandom_range(4, 29))
      send_byte($urandom_range(0, 15) == 0, 8'($urandom), 1'b0, none);
  endtask

  // result side: check each popped beat, stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        checked++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: vv=%0b vb=%h id=%h end=%0b idx=%0d st=%0d",
                     value_valid, value_byte, pair_id, pair_end, pair_index, parse_status);
        end else begin
          if (value_valid !== due_results[0].value_valid ||
              value_byte !== due_results[0].value_byte ||
              pair_id !== due_results[0].pair_id ||
              pair_end !== due_results[0].pair_end ||
              pair_index !== due_results[0].pair_index ||
              parse_status !== due_results[0].parse_status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat %0d mismatch: exp vv=%0b vb=%h id=%h end=%0b idx=%0d st=%0d",
                       checked, due_results[0].value_valid, due_results[0].value_byte,
                       due_results[0].pair_id, due_results[0].pair_end,
                       due_results[0].pair_index, due_results[0].parse_status);
              $display("  got vv=%0b vb=%h id=%h end=%0b idx=%0d st=%0d",
                       value_valid, value_byte, pair_id, pair_end, pair_index,
                       parse_status);
            end
          end
          void'(due_results.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cnt = 0;
    else quiet_cnt++;
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    result_t want;
    int dir_items;
    int kind;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty region after reset, then a byte past the finish
    dir_tab.insert(dir_tab.size(), dir_row(1, 32'd0, 1, 8'h00, 1, ST_DONE));
    dir_tab.insert(dir_tab.size(), dir_row(0, 32'd0, 0, 8'hFF, 1, ST_DONE));
    // one pair with a single value byte that fills the region exactly
    dir_tab.insert(dir_tab.size(), dir_row(1, 32'd13, 1, 8'h05, 0, ST_BUSY));
    repeat (7) dir_tab.insert(dir_tab.size(), dir_row(0, 32'd0, 0, 8'h00, 0, ST_BUSY));
    dir_tab.insert(dir_tab.size(), dir_row(0, 32'd0, 0, 8'h01, 0, ST_BUSY));
    dir_tab.insert(dir_tab.size(), dir_row(0, 32'd0, 0, 8'h02, 0, ST_BUSY));
    dir_tab.insert(dir_tab.size(), dir_row(0, 32'd0, 0, 8'h03, 0, ST_BUSY));
    dir_tab.insert(dir_tab.size(), dir_row(0, 32'd0, 0, 8'h84, 0, ST_BUSY));
    dir_tab.insert(dir_tab.size(), dir_row(0, 32'd0, 0, 8'hFF, 0, ST_BUSY));
    // all-ones length in a maximal region: flagged on the eighth byte, then ignored
    dir_tab.insert(dir_tab.size(), dir_row(1, 32'hFFFF_FFFF, 1, 8'hFF, 0, ST_BUSY));
    repeat (6) dir_tab.insert(dir_tab.size(), dir_row(0, 32'd0, 0, 8'hFF, 0, ST_BUSY));
    dir_tab.insert(dir_tab.size(), dir_row(0, 32'd0, 0, 8'hFF, 1, ST_ERROR));
    dir_tab.insert(dir_tab.size(), dir_row(0, 32'd0, 0, 8'h5A, 1, ST_ERROR));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) begin
        wait_idle();
        write_region_len(dir_tab[i].cfg);
      end
      want = '0;
      want.parse_status = dir_tab[i].status;
      send_byte(dir_tab[i].st, dir_tab[i].b, dir_tab[i].fixed, want);
    end
    dir_items = item_cnt;

    // random regions, mostly well formed, no idling near the end
    while (item_cnt < dir_items + RAND_ITEMS) begin
      bursts_on = (item_cnt < dir_items + RAND_ITEMS - CALM_ITEMS) &&
                  ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 19);
      if (kind < 14) run_region(1'b0);
      else if (kind < 16) run_region(1'b1);
      else run_noise();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("pushed %0d bytes over %0d region starts, %0d result beats checked",
             item_cnt, region_starts, checked);
    $display("pairs closed %0d, length errors %0d, clean finishes %0d",
             pairs_closed, len_errors, clean_ends);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
